@@ rtl/tks_pkg.sv @@
// Shared constants and types for the thresholded top-k selector.
`default_nettype none

package tks_pkg;

   localparam int SCORE_W       = 16;
   localparam int CLASS_INDEX_W = 10;
   localparam int TOP_COUNT_W   = 4;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 16;

   localparam int MAX_KEPT_DEF    = 8;
   localparam int MAX_CLASSES_DEF = 1024;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCORE_THRESHOLD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP_COUNT       = 1'd1;

   localparam logic [SCORE_W-1:0]     SCORE_THRESHOLD_RESET = '0;
   localparam logic [TOP_COUNT_W-1:0] TOP_COUNT_RESET       = 4'd5;

   typedef struct packed {
      logic step;
      logic last;
   } step_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/tks_if.sv @@
// Valid/ready channel interfaces for score input and selection results.
`default_nettype none

interface tks_req_if;
   logic                         valid;
   logic                         ready;
   logic [tks_pkg::SCORE_W-1:0]  score;
   logic                         last_score;

   modport source (output valid, score, last_score, input ready);
   modport sink   (input valid, score, last_score, output ready);
endinterface

interface tks_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [tks_pkg::CLASS_INDEX_W-1:0] class_index;
   logic [tks_pkg::SCORE_W-1:0]       class_score;
   logic                              found;
   logic                              overflow;
   logic                              last_result;

   modport source (output valid, class_index, class_score, found, overflow, last_result,
                   input ready);
   modport sink   (input valid, class_index, class_score, found, overflow, last_result,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/tks_index.sv @@
// Position counter: numbers scores within a vector and flags index overflow.
`default_nettype none

module tks_index #(
   parameter int MAX_CLASSES = tks_pkg::MAX_CLASSES_DEF,
   localparam int IW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tks_pkg::step_ctrl_type ctrl,
   output logic [IW-1:0]               item_index,
   output logic                        item_overflow
);

   localparam logic [IW-1:0] LAST_INDEX = IW'(MAX_CLASSES - 1);

   logic [IW-1:0] position_ff, position_in;
   logic          used_ff, used_in;
   logic          overflowed_ff, overflowed_in;

   assign item_index    = used_ff ? LAST_INDEX : position_ff;
   assign item_overflow = overflowed_ff | used_ff;

   always_comb begin
      position_in   = position_ff;
      used_in       = used_ff;
      overflowed_in = overflowed_ff;
      if (ctrl.step && ctrl.last) begin
         position_in   = '0;
         used_in       = 1'b0;
         overflowed_in = 1'b0;
      end else if (ctrl.step) begin
         if (used_ff) begin
            overflowed_in = 1'b1;
         end else if (position_ff == LAST_INDEX) begin
            used_in = 1'b1;
         end else begin
            position_in = position_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         used_ff       <= 1'b0;
         overflowed_ff <= 1'b0;
      end else begin
         position_ff   <= position_in;
         used_ff       <= used_in;
         overflowed_ff <= overflowed_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/tks_list.sv @@
// Sorted kept list: parallel compare, insert and evict of one pair per cycle.
`default_nettype none

module tks_list #(
   parameter int MAX_KEPT = tks_pkg::MAX_KEPT_DEF,
   parameter int IW       = 10,
   localparam int CW = $clog2(MAX_KEPT + 1)
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire tks_pkg::step_ctrl_type                    ctrl,
   input  wire logic [tks_pkg::SCORE_W-1:0]               score,
   input  wire logic [IW-1:0]                             item_index,
   input  wire logic [tks_pkg::SCORE_W-1:0]               score_threshold,
   input  wire logic [tks_pkg::TOP_COUNT_W-1:0]           top_count,
   output logic [MAX_KEPT-1:0][tks_pkg::SCORE_W-1:0]      next_scores,
   output logic [MAX_KEPT-1:0][IW-1:0]                    next_indices,
   output logic [CW-1:0]                                  next_count
);

   localparam int CAP_W = (CW > tks_pkg::TOP_COUNT_W) ? CW : tks_pkg::TOP_COUNT_W;

   logic [MAX_KEPT-1:0][tks_pkg::SCORE_W-1:0] scores_ff, scores_in;
   logic [MAX_KEPT-1:0][IW-1:0]               indices_ff, indices_in;
   logic [CW-1:0]                             count_ff, count_in;

   logic [MAX_KEPT:0]                         ge;
   logic [MAX_KEPT:0][tks_pkg::SCORE_W-1:0]   ext_scores;
   logic [MAX_KEPT:0][IW-1:0]                 ext_indices;
   logic [CAP_W-1:0]                          top_ext, cap;
   logic [CAP_W:0]                            count_plus;
   logic                                      pass, drop;

   // rank the new pair against each valid kept pair
   always_comb begin
      ge = '0;
      for (int k = 0; k < MAX_KEPT; k++) begin
         ge[k] = (CW'(k) < count_ff) &&
                 ((score > scores_ff[k]) ||
                  ((score == scores_ff[k]) && (item_index >= indices_ff[k])));
      end
   end

   // list with the new pair slotted in, one entry longer
   always_comb begin
      ext_scores[0]  = ge[0] ? scores_ff[0]  : score;
      ext_indices[0] = ge[0] ? indices_ff[0] : item_index;
      for (int j = 1; j <= MAX_KEPT; j++) begin
         if (j < MAX_KEPT && ge[j]) begin
            ext_scores[j]  = scores_ff[j % MAX_KEPT];
            ext_indices[j] = indices_ff[j % MAX_KEPT];
         end else if (ge[j-1]) begin
            ext_scores[j]  = score;
            ext_indices[j] = item_index;
         end else begin
            ext_scores[j]  = scores_ff[j-1];
            ext_indices[j] = indices_ff[j-1];
         end
      end
   end

   assign top_ext    = CAP_W'(top_count);
   assign cap        = (top_ext > CAP_W'(MAX_KEPT)) ? CAP_W'(MAX_KEPT) : top_ext;
   assign count_plus = (CAP_W + 1)'(count_ff) + (CAP_W + 1)'(1);
   assign pass       = score >= score_threshold;
   assign drop       = (count_ff == CW'(MAX_KEPT)) || (count_plus > {1'b0, cap});

   always_comb begin
      next_scores  = scores_ff;
      next_indices = indices_ff;
      next_count   = count_ff;
      if (pass) begin
         for (int j = 0; j < MAX_KEPT; j++) begin
            next_scores[j]  = drop ? ext_scores[j+1]  : ext_scores[j];
            next_indices[j] = drop ? ext_indices[j+1] : ext_indices[j];
         end
         next_count = drop ? count_ff : count_ff + CW'(1);
      end
   end

   always_comb begin
      scores_in  = scores_ff;
      indices_in = indices_ff;
      count_in   = count_ff;
      if (ctrl.step && ctrl.last) begin
         count_in = '0;
      end else if (ctrl.step) begin
         scores_in  = next_scores;
         indices_in = next_indices;
         count_in   = next_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      scores_ff  <= scores_in;
      indices_ff <= indices_in;
   end

endmodule

`default_nettype wire

@@ rtl/tks_drain.sv @@
// Result buffer: holds a finished list and emits it highest entry first.
`default_nettype none

module tks_drain #(
   parameter int MAX_KEPT = tks_pkg::MAX_KEPT_DEF,
   parameter int IW       = 10,
   localparam int CW = $clog2(MAX_KEPT + 1),
   localparam int KW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   load,
   input  wire logic [MAX_KEPT-1:0][tks_pkg::SCORE_W-1:0] load_scores,
   input  wire logic [MAX_KEPT-1:0][IW-1:0]            load_indices,
   input  wire logic [CW-1:0]                          load_count,
   input  wire logic                                   load_overflow,
   output logic                                        load_free,
   tks_rsp_if.source                                   rsp_ch
);

   logic [MAX_KEPT-1:0][tks_pkg::SCORE_W-1:0] hold_scores_ff, hold_scores_in;
   logic [MAX_KEPT-1:0][IW-1:0]               hold_indices_ff, hold_indices_in;
   logic                                      hold_overflow_ff, hold_overflow_in;
   logic [CW-1:0]                             remain_ff, remain_in;
   logic                                      busy_ff, busy_in;

   logic [KW-1:0] rd_sel;
   logic          found, final_result, pop;

   assign found        = remain_ff != '0;
   assign final_result = remain_ff <= CW'(1);
   assign rd_sel       = KW'(remain_ff - CW'(1));
   assign pop          = busy_ff && rsp_ch.ready;
   assign load_free    = !busy_ff || (pop && final_result);

   assign rsp_ch.valid       = busy_ff;
   assign rsp_ch.found       = found;
   assign rsp_ch.class_score = found ? hold_scores_ff[rd_sel] : '0;
   assign rsp_ch.class_index = found ? tks_pkg::CLASS_INDEX_W'(hold_indices_ff[rd_sel]) : '0;
   assign rsp_ch.overflow    = hold_overflow_ff;
   assign rsp_ch.last_result = final_result;

   always_comb begin
      busy_in          = busy_ff;
      remain_in        = remain_ff;
      hold_scores_in   = hold_scores_ff;
      hold_indices_in  = hold_indices_ff;
      hold_overflow_in = hold_overflow_ff;
      if (load) begin
         busy_in          = 1'b1;
         remain_in        = load_count;
         hold_scores_in   = load_scores;
         hold_indices_in  = load_indices;
         hold_overflow_in = load_overflow;
      end else if (pop) begin
         if (final_result) begin
            busy_in = 1'b0;
         end else begin
            remain_in = remain_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         remain_ff <= '0;
      end else begin
         busy_ff   <= busy_in;
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_scores_ff   <= hold_scores_in;
      hold_indices_ff  <= hold_indices_in;
      hold_overflow_ff <= hold_overflow_in;
   end

endmodule

`default_nettype wire

@@ rtl/thresholded_top_k_select.sv @@
// Top level of the thresholded top-k selector.
//
// Scores arrive on req_ch, one per transaction, numbered from 0 within a vector;
// last_score closes the vector. Each accepted score is compared against the kept
// list in the same cycle, so a score can be taken on every clock while req_ch.ready is high.
// When the closing score is accepted, the finished list moves into the result
// buffer and the list clears; the next vector may start on the following cycle.
// Results appear on rsp_ch from the cycle after the closing score, one per cycle
// while rsp_ch.ready is high: the kept entries from best to worst, or a single
// result with found low when nothing passed the threshold.
// A run of results drains while the next vector streams in.
// A stalled receiver only holds back the next closing score: req_ch.ready drops
// for a last_score transaction until the buffered run has fully drained.
// csr_we writes score_threshold (index 0) or top_count (index 1); write only
// while idle.
// Synchronous reset clears the list, position counter and result buffer and
// restores the register defaults.
`default_nettype none

module thresholded_top_k_select #(
   parameter int MAX_KEPT    = tks_pkg::MAX_KEPT_DEF,
   parameter int MAX_CLASSES = tks_pkg::MAX_CLASSES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   tks_req_if.sink                               req_ch,
   tks_rsp_if.source                             rsp_ch,
   input  wire logic                             csr_we,
   input  wire logic [tks_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [tks_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int CW = $clog2(MAX_KEPT + 1);

   logic [tks_pkg::SCORE_W-1:0]     score_threshold_ff, score_threshold_in;
   logic [tks_pkg::TOP_COUNT_W-1:0] top_count_ff, top_count_in;

   tks_pkg::step_ctrl_type                    ctrl;
   logic [IW-1:0]                             item_index;
   logic                                      item_overflow;
   logic [MAX_KEPT-1:0][tks_pkg::SCORE_W-1:0] next_scores;
   logic [MAX_KEPT-1:0][IW-1:0]               next_indices;
   logic [CW-1:0]                             next_count;
   logic                                      load_free;

   assign req_ch.ready = !req_ch.last_score || load_free;
   assign ctrl.step    = req_ch.valid && req_ch.ready;
   assign ctrl.last    = req_ch.last_score;

   always_comb begin
      score_threshold_in = score_threshold_ff;
      top_count_in       = top_count_ff;
      if (csr_we) begin
         case (csr_index)
            tks_pkg::CSR_SCORE_THRESHOLD: begin
               score_threshold_in = csr_wdata[tks_pkg::SCORE_W-1:0];
            end
            tks_pkg::CSR_TOP_COUNT: begin
               top_count_in = csr_wdata[tks_pkg::TOP_COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         score_threshold_ff <= tks_pkg::SCORE_THRESHOLD_RESET;
         top_count_ff       <= tks_pkg::TOP_COUNT_RESET;
      end else begin
         score_threshold_ff <= score_threshold_in;
         top_count_ff       <= top_count_in;
      end
   end

   tks_index #(
      .MAX_CLASSES (MAX_CLASSES)
   ) u_index (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .item_index    (item_index),
      .item_overflow (item_overflow)
   );

   tks_list #(
      .MAX_KEPT (MAX_KEPT),
      .IW       (IW)
   ) u_list (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .score           (req_ch.score),
      .item_index      (item_index),
      .score_threshold (score_threshold_ff),
      .top_count       (top_count_ff),
      .next_scores     (next_scores),
      .next_indices    (next_indices),
      .next_count      (next_count)
   );

   tks_drain #(
      .MAX_KEPT (MAX_KEPT),
      .IW       (IW)
   ) u_drain (
      .clock         (clock),
      .reset         (reset),
      .load          (ctrl.step && ctrl.last),
      .load_scores   (next_scores),
      .load_indices  (next_indices),
      .load_count    (next_count),
      .load_overflow (item_overflow),
      .load_free     (load_free),
      .rsp_ch        (rsp_ch)
   );

endmodule

`default_nettype wire
